[src/lbrm_pkg.sv]
// Shared types, constants and the sine table function of the laser beam region mask.
package lbrm_pkg;

    localparam int MAX_BEAMS_DEF    = 2048;
    localparam int SELF_REGIONS_DEF = 4;
    localparam int SINE_BITS_DEF    = 8;

    localparam int RANGE_W    = 16;
    localparam int IDX_W      = 11;
    localparam int ANGLE_W    = 16;
    localparam int TRIG_W     = 16;
    localparam int PROD_W     = 33;
    localparam int COORD_W    = 18;
    localparam int BOUND_W    = 12;
    localparam int RECT_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SETUP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_REGION_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NAV_REGION    = 3'd6;

    localparam logic [31:0]       RANGE_LIMITS_RST = 32'hFFFF_0000;
    localparam logic [31:0]       ANGLE_SETUP_RST  = 32'h0000_0000;
    localparam logic [RECT_W-1:0] SELF_REGION_RST  = 48'h0000_0000_0000;
    localparam logic [RECT_W-1:0] NAV_REGION_RST   = 48'h064F_9C06_4F9C;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic [IDX_W-1:0]   idx;
        logic               live;
        logic [ANGLE_W-1:0] angle;
    } angle_beat_t;

    typedef struct packed {
        logic [RANGE_W-1:0]       range;
        logic [IDX_W-1:0]         idx;
        logic                     live;
        logic signed [TRIG_W-1:0] sin_q;
        logic signed [TRIG_W-1:0] cos_q;
    } trig_beat_t;

    typedef struct packed {
        logic [RANGE_W-1:0]       range;
        logic [IDX_W-1:0]         idx;
        logic                     live;
        logic signed [PROD_W-1:0] px;
        logic signed [PROD_W-1:0] py;
    } prod_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [RANGE_W-1:0] self_range;
        logic [RANGE_W-1:0] nav_range;
        logic               self_hit;
        logic               nav_hit;
    } out_beat_t;

    // Quarter-wave sine entry k in Q1.15, from a Taylor series in Q30.
    function automatic logic [TRIG_W-1:0] sine_entry(input int k, input int bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        x = (HALF_PI_Q30 * 64'(k)) >> bits;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        q = (sum + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[TRIG_W-1:0];
    endfunction

endpackage

[src/lbrm_angle.sv]
// First stage: range qualification and beam angle from start plus index times step.
module lbrm_angle import lbrm_pkg::*; #(
    parameter int MAX_BEAMS = MAX_BEAMS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [RANGE_W-1:0] in_range,
    input  logic               in_ok,
    input  logic [IDX_W-1:0]   in_idx,
    input  logic [31:0]        range_limits,
    input  logic [31:0]        angle_setup,
    output logic               out_valid,
    input  logic               out_ready,
    output angle_beat_t        out_beat
);

    logic        valid_reg;
    angle_beat_t beat_reg;
    angle_beat_t beat_next;
    logic        advance;
    logic [IDX_W+ANGLE_W-1:0] prod;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb begin
        prod = {{ANGLE_W{1'b0}}, in_idx} * {{IDX_W{1'b0}}, angle_setup[31:16]};
        beat_next.range = in_range;
        beat_next.idx   = in_idx;
        beat_next.live  = in_ok
                          && ({6'd0, in_idx} < 17'(MAX_BEAMS))
                          && (in_range >= range_limits[15:0])
                          && (in_range <= range_limits[31:16]);
        beat_next.angle = angle_setup[15:0] + prod[ANGLE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

[src/lbrm_trig.sv]
// Second stage: sine and cosine lookup in a quarter-wave table.
module lbrm_trig import lbrm_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  angle_beat_t in_beat,
    output logic        out_valid,
    input  logic        out_ready,
    output trig_beat_t  out_beat
);

    localparam int ROM_N = (1 << SINE_TABLE_BITS) + 1;
    localparam logic [SINE_TABLE_BITS:0] FULL = (SINE_TABLE_BITS + 1)'(1 << SINE_TABLE_BITS);

    logic [TRIG_W-1:0] rom [ROM_N];

    for (genvar k = 0; k < ROM_N; k++) begin : g_rom
        localparam logic [TRIG_W-1:0] ENTRY = sine_entry(k, SINE_TABLE_BITS);
        assign rom[k] = ENTRY;
    end

    logic       valid_reg;
    trig_beat_t beat_reg;
    trig_beat_t beat_next;
    logic       advance;

    logic [ANGLE_W-1:0]         cos_angle;
    logic [SINE_TABLE_BITS:0]   sin_addr;
    logic [SINE_TABLE_BITS:0]   cos_addr;
    logic signed [TRIG_W-1:0]   sin_mag;
    logic signed [TRIG_W-1:0]   cos_mag;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb begin
        cos_angle = in_beat.angle + 16'h4000;
        sin_addr = {1'b0, in_beat.angle[13 -: SINE_TABLE_BITS]};
        if (in_beat.angle[14]) begin
            sin_addr = FULL - sin_addr;
        end
        cos_addr = {1'b0, cos_angle[13 -: SINE_TABLE_BITS]};
        if (cos_angle[14]) begin
            cos_addr = FULL - cos_addr;
        end
        sin_mag = $signed(rom[sin_addr]);
        cos_mag = $signed(rom[cos_addr]);
        beat_next.range = in_beat.range;
        beat_next.idx   = in_beat.idx;
        beat_next.live  = in_beat.live;
        beat_next.sin_q = in_beat.angle[15] ? -sin_mag : sin_mag;
        beat_next.cos_q = cos_angle[15] ? -cos_mag : cos_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

[src/lbrm_scale.sv]
// Third stage: range times cosine and range times sine.
module lbrm_scale import lbrm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  trig_beat_t in_beat,
    output logic       out_valid,
    input  logic       out_ready,
    output prod_beat_t out_beat
);

    logic       valid_reg;
    prod_beat_t beat_reg;
    prod_beat_t beat_next;
    logic       advance;
    logic signed [RANGE_W:0] range_s;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb begin
        range_s = $signed({1'b0, in_beat.range});
        beat_next.range = in_beat.range;
        beat_next.idx   = in_beat.idx;
        beat_next.live  = in_beat.live;
        beat_next.px    = PROD_W'(range_s) * PROD_W'(in_beat.cos_q);
        beat_next.py    = PROD_W'(range_s) * PROD_W'(in_beat.sin_q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

[src/lbrm_region.sv]
// Last stage: rounding to centimetres, rectangle tests and range replacement.
module lbrm_region import lbrm_pkg::*; #(
    parameter int SELF_REGIONS = SELF_REGIONS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  prod_beat_t         in_beat,
    input  logic [RANGE_W-1:0] repl_range,
    input  logic [RECT_W-1:0]  self_rects [SELF_REGIONS],
    input  logic [RECT_W-1:0]  nav_rect,
    output logic               out_valid,
    input  logic               out_ready,
    output out_beat_t          out_beat
);

    function automatic logic in_rect(input logic [RECT_W-1:0] rect,
                                     input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y);
        logic signed [COORD_W-1:0] b [4];
        for (int k = 0; k < 4; k++) begin
            b[k] = $signed({{(COORD_W-BOUND_W){rect[BOUND_W*k+BOUND_W-1]}},
                            rect[BOUND_W*k +: BOUND_W]});
        end
        return (x >= b[0]) && (x <= b[1]) && (y >= b[2]) && (y <= b[3]);
    endfunction

    logic      valid_reg;
    out_beat_t beat_reg;
    out_beat_t beat_next;
    logic      advance;
    logic signed [PROD_W-1:0]  sum_x;
    logic signed [PROD_W-1:0]  sum_y;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic self_any;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb begin
        sum_x = in_beat.px + PROD_W'(16384);
        sum_y = in_beat.py + PROD_W'(16384);
        x = sum_x[PROD_W-1:15];
        y = sum_y[PROD_W-1:15];
        self_any = 1'b0;
        for (int i = 0; i < SELF_REGIONS; i++) begin
            self_any = self_any | in_rect(self_rects[i], x, y);
        end
        beat_next.idx        = in_beat.idx;
        beat_next.self_hit   = in_beat.live && self_any;
        beat_next.nav_hit    = in_beat.live && in_rect(nav_rect, x, y);
        beat_next.self_range = beat_next.self_hit ? repl_range : in_beat.range;
        beat_next.nav_range  = beat_next.nav_hit ? repl_range : in_beat.range;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

[src/laser_beam_region_mask_core.sv]
// Top level of the laser beam region mask: configuration registers and a four-stage pipeline.
//
//   Channel  Direction  Transfer condition      Contents
//   s_       in         s_tvalid && s_tready    one beam: range, validity, index
//   m_       out        m_tvalid && m_tready    index, two filtered ranges, hit flags
//   cfg_     in         cfg_we                  one register write by index
//
// A beam passes through four stages, angle, table lookup, multiply and rectangle test, on its
// way from its transaction to its result on the m_ side, and a new beam can enter every cycle
// unless a stall on the m_ side has filled every stage. Reset is synchronous and empties all
// stages and restores the register defaults. A stall on the m_ side holds each stage that is
// full, while empty stages still take data, so s_tready drops only when every stage holds a beam.
module laser_beam_region_mask_core import lbrm_pkg::*; #(
    parameter int MAX_BEAMS       = MAX_BEAMS_DEF,
    parameter int SELF_REGIONS    = SELF_REGIONS_DEF,
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // range_cm[15:0], beam_index[26:16]
    input  logic [0:0]            s_tuser,   // range_ok[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // beam_out[10:0], self_filtered_range[26:11],
                                             // nav_filtered_range[42:27]
    output logic [1:0]            m_tuser,   // self_hit[0], nav_hit[1]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [31:0]     range_limits_reg;
    logic [31:0]     angle_setup_reg;
    logic [RECT_W-1:0] self_region_reg [SELF_REGIONS];
    logic [RECT_W-1:0] nav_region_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_limits_reg <= RANGE_LIMITS_RST;
            angle_setup_reg  <= ANGLE_SETUP_RST;
            nav_region_reg   <= NAV_REGION_RST;
        end else if (cfg_we) begin
            if (cfg_index == REG_RANGE_LIMITS) begin
                range_limits_reg <= cfg_wdata[31:0];
            end
            if (cfg_index == REG_ANGLE_SETUP) begin
                angle_setup_reg <= cfg_wdata[31:0];
            end
            if (cfg_index == REG_NAV_REGION) begin
                nav_region_reg <= cfg_wdata[RECT_W-1:0];
            end
        end
    end

    for (genvar i = 0; i < SELF_REGIONS; i++) begin : g_self
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                self_region_reg[i] <= SELF_REGION_RST;
            end else if (cfg_we && cfg_index == REG_SELF_REGION_0 + CFG_IDX_W'(i)) begin
                self_region_reg[i] <= cfg_wdata[RECT_W-1:0];
            end
        end
    end

    logic        a_valid;
    logic        a_ready;
    angle_beat_t a_beat;
    logic        t_valid;
    logic        t_ready;
    trig_beat_t  t_beat;
    logic        p_valid;
    logic        p_ready;
    prod_beat_t  p_beat;
    out_beat_t   o_beat;

    lbrm_angle #(
        .MAX_BEAMS(MAX_BEAMS)
    ) u_angle (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_range    (s_tdata[15:0]),
        .in_ok       (s_tuser[0]),
        .in_idx      (s_tdata[26:16]),
        .range_limits(range_limits_reg),
        .angle_setup (angle_setup_reg),
        .out_valid   (a_valid),
        .out_ready   (a_ready),
        .out_beat    (a_beat)
    );

    lbrm_trig #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_trig (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (a_valid),
        .in_ready (a_ready),
        .in_beat  (a_beat),
        .out_valid(t_valid),
        .out_ready(t_ready),
        .out_beat (t_beat)
    );

    lbrm_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (t_valid),
        .in_ready (t_ready),
        .in_beat  (t_beat),
        .out_valid(p_valid),
        .out_ready(p_ready),
        .out_beat (p_beat)
    );

    lbrm_region #(
        .SELF_REGIONS(SELF_REGIONS)
    ) u_region (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_beat   (p_beat),
        .repl_range(range_limits_reg[31:16]),
        .self_rects(self_region_reg),
        .nav_rect  (nav_region_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (o_beat)
    );

    assign m_tdata = {5'd0, o_beat.nav_range, o_beat.self_range, o_beat.idx};
    assign m_tuser = {o_beat.nav_hit, o_beat.self_hit};

endmodule

[src/lbrm_checker.sv]
// Port-level checks of the laser beam region mask, bound to the top level.
module lbrm_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [47:0]           m_tdata,
    input logic [1:0]            m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed or vanished while stalled");

    a_ready_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> s_tready)
        else $error("input not ready after reset");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
        else $error("result appeared without a transaction four cycles earlier");

    a_equal_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == m_tuser[1]) |-> m_tdata[26:11] == m_tdata[42:27])
        else $error("filtered ranges differ although both hit flags agree");

endmodule

bind laser_beam_region_mask_core lbrm_checker u_lbrm_checker (.*);

[test/laser_beam_region_mask_core_tb.sv]
// Self-checking testbench for the laser beam region mask core, with a scoreboard class.
module laser_beam_region_mask_core_tb import lbrm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_BITS     = SINE_BITS_DEF;
    localparam int TBL_SIZE     = (1 << TBL_BITS) + 1;
    localparam int PIPE_LATENCY = 4;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASE_BEAMS  = 250;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        logic [IDX_W-1:0]   beam;
        logic [RANGE_W-1:0] self_range;
        logic [RANGE_W-1:0] nav_range;
        logic               self_hit;
        logic               nav_hit;
    } beam_verdict_t;

    class region_mask_scoreboard;
        logic [31:0]       range_limits;
        logic [31:0]       angle_setup;
        logic [RECT_W-1:0] self_rect [SELF_REGIONS_DEF];
        logic [RECT_W-1:0] nav_rect;
        int                sine_q15 [TBL_SIZE];
        beam_verdict_t     expected_beams [$];
        int                errors;

        function new();
            range_limits = RANGE_LIMITS_RST;
            angle_setup = ANGLE_SETUP_RST;
            for (int i = 0; i < SELF_REGIONS_DEF; i++) begin
                self_rect[i] = SELF_REGION_RST;
            end
            nav_rect = NAV_REGION_RST;
            errors = 0;
            build_table();
        endfunction

        // Quarter-wave sine in Q1.15 from a Taylor series evaluated in Q30.
        function void build_table();
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] sum;
            logic [63:0] q;
            for (int k = 0; k < TBL_SIZE; k++) begin
                x = (HALF_PI_Q30 * 64'(k)) >> TBL_BITS;
                x2 = (x * x) >> 30;
                term = x;
                sum = x;
                for (int n = 1; n <= 8; n++) begin
                    term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
                q = (sum + 64'd16384) >> 15;
                if (q > 64'd32767) begin
                    q = 64'd32767;
                end
                sine_q15[k] = int'(q);
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_RANGE_LIMITS: range_limits = val[31:0];
                REG_ANGLE_SETUP:  angle_setup = val[31:0];
                REG_NAV_REGION:   nav_rect = val[RECT_W-1:0];
                default: begin
                    if (idx >= REG_SELF_REGION_0 && idx < REG_SELF_REGION_0 + SELF_REGIONS_DEF)
                    begin
                        self_rect[idx - REG_SELF_REGION_0] = val[RECT_W-1:0];
                    end
                end
            endcase
        endfunction

        function int trig_of(logic [ANGLE_W-1:0] a);
            int addr;
            int v;
            addr = int'(a[13:0]) >> (14 - TBL_BITS);
            v = a[14] ? sine_q15[(1 << TBL_BITS) - addr] : sine_q15[addr];
            return a[15] ? -v : v;
        endfunction

        // Rounds range times trig to the nearest whole centimeter, with halves rounded up.
        function longint project(logic [RANGE_W-1:0] r, int t);
            longint p;
            p = longint'(r) * longint'(t) + 64'sd16384;
            return p >>> 15;
        endfunction

        function int bound(logic [RECT_W-1:0] rect, int k);
            return int'($signed(rect[BOUND_W*k +: BOUND_W]));
        endfunction

        function bit contains(logic [RECT_W-1:0] rect, longint x, longint y);
            return x >= bound(rect, 0) && x <= bound(rect, 1) &&
                   y >= bound(rect, 2) && y <= bound(rect, 3);
        endfunction

        function beam_verdict_t mask_beam(logic [RANGE_W-1:0] r, logic ok,
                                          logic [IDX_W-1:0] idx);
            beam_verdict_t v;
            logic [RANGE_W-1:0] rmin;
            logic [RANGE_W-1:0] rmax;
            logic [ANGLE_W-1:0] angle;
            longint x;
            longint y;
            v.beam = idx;
            v.self_range = r;
            v.nav_range = r;
            v.self_hit = 1'b0;
            v.nav_hit = 1'b0;
            rmin = range_limits[15:0];
            rmax = range_limits[31:16];
            if (ok && int'(idx) < MAX_BEAMS_DEF && r >= rmin && r <= rmax) begin
                angle = angle_setup[15:0] + idx * angle_setup[31:16];
                x = project(r, trig_of(angle + 16'd16384));
                y = project(r, trig_of(angle));
                for (int i = 0; i < SELF_REGIONS_DEF; i++) begin
                    if (contains(self_rect[i], x, y)) begin
                        v.self_hit = 1'b1;
                    end
                end
                v.nav_hit = contains(nav_rect, x, y);
                if (v.self_hit) begin
                    v.self_range = rmax;
                end
                if (v.nav_hit) begin
                    v.nav_range = rmax;
                end
            end
            return v;
        endfunction

        function void note_beam(logic [RANGE_W-1:0] r, logic ok, logic [IDX_W-1:0] idx);
            expected_beams.push_back(mask_beam(r, ok, idx));
        endfunction

        function void check_result(logic [47:0] d, logic [1:0] u);
            beam_verdict_t e;
            if (expected_beams.size() == 0) begin
                $error("result transaction with no beam pending: tdata %h tuser %b", d, u);
                errors++;
                return;
            end
            e = expected_beams.pop_front();
            if (d[10:0] !== e.beam) begin
                $error("beam_out expected %0d actual %0d", e.beam, d[10:0]);
                errors++;
            end
            if (d[26:11] !== e.self_range) begin
                $error("self_filtered_range expected %0d actual %0d", e.self_range, d[26:11]);
                errors++;
            end
            if (d[42:27] !== e.nav_range) begin
                $error("nav_filtered_range expected %0d actual %0d", e.nav_range, d[42:27]);
                errors++;
            end
            if (u[0] !== e.self_hit) begin
                $error("self_hit expected %0d actual %0d", e.self_hit, u[0]);
                errors++;
            end
            if (u[1] !== e.nav_hit) begin
                $error("nav_hit expected %0d actual %0d", e.nav_hit, u[1]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    region_mask_scoreboard sb = new();

    int tx_idle_pct = 36;
    int rx_idle_pct = 84;
    int stall_req = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    laser_beam_region_mask_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (stall_req > 0) begin
            stall_left = stall_req;
            stall_req = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) begin
                sb.write_reg(cfg_index, cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_beam(s_tdata[15:0], s_tuser[0], s_tdata[26:16]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("laser_beam_region_mask_core_tb: errors");
            $finish;
        end
    end

    task automatic send_beam(input logic [RANGE_W-1:0] r, input logic ok,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, idx, r};
        s_tuser <= ok;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Drops valid, then waits until every beam has come back and the pipeline is empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_beams.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_regs(input logic [31:0] limits, input logic [31:0] angle,
                             input logic [RECT_W-1:0] r0, input logic [RECT_W-1:0] r1,
                             input logic [RECT_W-1:0] r2, input logic [RECT_W-1:0] r3,
                             input logic [RECT_W-1:0] nav);
        set_reg(REG_RANGE_LIMITS, {16'($urandom), limits});
        set_reg(REG_ANGLE_SETUP, {16'($urandom), angle});
        set_reg(REG_SELF_REGION_0, r0);
        set_reg(REG_SELF_REGION_0 + 3'd1, r1);
        set_reg(REG_SELF_REGION_0 + 3'd2, r2);
        set_reg(REG_SELF_REGION_0 + 3'd3, r3);
        set_reg(REG_NAV_REGION, nav);
        set_reg(REG_SPARE, {16'($urandom), 32'($urandom)});
    endtask

    function automatic logic [RECT_W-1:0] pack_rect(int x0, int x1, int y0, int y1);
        return {12'(y1), 12'(y0), 12'(x1), 12'(x0)};
    endfunction

    function automatic logic [RECT_W-1:0] random_rect();
        int x0;
        int y0;
        x0 = int'($urandom_range(800, 0)) - 400;
        y0 = int'($urandom_range(800, 0)) - 400;
        case ($urandom_range(9, 0))
            0: return pack_rect(-2048, 2047, -2048, 2047);
            1: return {16'($urandom), 32'($urandom)};
            2: return pack_rect(x0, x0 - 1 - int'($urandom_range(50, 0)), -300, 300);
            3: return pack_rect(-300, 300, y0, y0 - 1 - int'($urandom_range(50, 0)));
            default: return pack_rect(x0, x0 + int'($urandom_range(500, 0)),
                                      y0, y0 + int'($urandom_range(500, 0)));
        endcase
    endfunction

    function automatic logic [RANGE_W-1:0] pick_range();
        int lo;
        int hi;
        int span;
        lo = int'(sb.range_limits[15:0]);
        hi = int'(sb.range_limits[31:16]);
        span = hi - lo;
        case ($urandom_range(9, 0))
            0: return 16'($urandom);
            1: return 16'(lo);
            2: return 16'(hi);
            3: return (span < 0) ? 16'($urandom) : 16'(lo + int'($urandom_range(span, 0)));
            default: begin
                if (span < 0) begin
                    return 16'($urandom);
                end
                return 16'(lo + int'($urandom_range((span > 800) ? 800 : span, 0)));
            end
        endcase
    endfunction

    task automatic configure_phase(input int ph);
        logic [31:0] limits;
        logic [31:0] angle;
        int lo;
        case (ph)
            0: begin
                limits = 32'hFFFF_0000;
                angle = {16'd32, 16'($urandom)};
            end
            1: begin
                limits = {16'($urandom_range(1500, 300)), 16'($urandom_range(60, 0))};
                angle = {16'hFFE0, 16'($urandom)};
            end
            2: begin
                limits = {16'd2000, 16'd0};
                angle = {16'h7FFF, 16'hFFFF};
            end
            3: begin
                limits = {16'hFFFF, 16'($urandom_range(400, 100))};
                angle = {16'h8000, 16'h0000};
            end
            4: begin
                limits = {16'd65535, 16'd0};
                angle = $urandom;
            end
            default: begin
                lo = int'($urandom_range(1000, 0));
                limits = {16'(lo + int'($urandom_range(3000, 0))), 16'(lo)};
                angle = {16'(int'($urandom_range(64, 0)) - 32), 16'($urandom)};
            end
        endcase
        load_regs(limits, angle, random_rect(), random_rect(), random_rect(), random_rect(),
                  random_rect());
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Power-on registers: every beam points along +x, nav box from -100 to 100 cm in x and y.
        send_beam(16'd0, 1'b1, 11'd0);
        send_beam(16'd100, 1'b1, 11'd0);
        send_beam(16'd101, 1'b1, 11'd1);
        send_beam(16'd65535, 1'b1, 11'd2047);
        send_beam(16'd50, 1'b0, 11'd0);
        send_beam(16'd0, 1'b0, 11'd2047);
        send_beam(16'd1, 1'b1, 11'd1024);
        send_beam(16'd32768, 1'b1, 11'd3);
        settle();

        // Quarter-turn steps, range window 10..200, inverted and full-plane boxes.
        load_regs({16'd200, 16'd10}, {16'd16384, 16'd16384},
                  pack_rect(10, -10, -5, 5), pack_rect(-60, -40, -10, 10),
                  48'd0, pack_rect(-2048, 2047, -2048, -2048),
                  pack_rect(-2048, 2047, -2048, 2047));
        send_beam(16'd9, 1'b1, 11'd0);
        send_beam(16'd10, 1'b1, 11'd0);
        send_beam(16'd200, 1'b1, 11'd1);
        send_beam(16'd201, 1'b1, 11'd2);
        send_beam(16'd50, 1'b1, 11'd0);
        send_beam(16'd50, 1'b1, 11'd1);
        send_beam(16'd50, 1'b1, 11'd2);
        send_beam(16'd50, 1'b1, 11'd3);
        send_beam(16'd50, 1'b0, 11'd1);
        send_beam(16'd0, 1'b1, 11'd4);
        send_beam(16'd150, 1'b1, 11'd2047);
        send_beam(16'd65535, 1'b1, 11'd5);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            configure_phase(ph);
            if (ph < 2) begin
                tx_idle_pct = 36;
                rx_idle_pct = 84;
            end else if (ph < 4) begin
                tx_idle_pct = 84;
                rx_idle_pct = 36;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_BEAMS; n++) begin
                if (ph == 4 && n == 40) begin
                    stall_req = 80;
                end
                send_beam(pick_range(), ($urandom_range(9, 0) != 0), 11'($urandom));
            end
            settle();
        end

        if (sb.errors == 0 && sb.expected_beams.size() == 0) begin
            $display("laser_beam_region_mask_core_tb: clean");
        end else begin
            $display("laser_beam_region_mask_core_tb: errors");
        end
        $finish;
    end

endmodule
